[hw/rtl/hkvs_pkg.sv]
// package: request, result, table entry and sequencer types for the key-value store
package hkvs_pkg;

  localparam int unsigned KeyW   = 63;
  localparam int unsigned ValueW = 64;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_SEARCH = 2'd2
  } func_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_UPDATED   = 3'd1,
    STAT_DELETED   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FOUND     = 3'd4,
    STAT_FULL      = 3'd5
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FOLD,
    S_QUOT,
    S_REM,
    S_FIX,
    S_READ,
    S_EXEC
  } state_t;

  typedef struct packed {
    func_t                     func;
    logic [KeyW-1:0]           key;
    logic signed [ValueW-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [ValueW-1:0]  read_value;
  } out_item_t;

  // one way of a bucket row
  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } way_t;

endpackage

[hw/rtl/hkvs_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module hkvs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/hashed_key_value_store_core.sv]
// Hashed key-value store: BUCKETS rows of WAYS entries, read-modify-write of one bucket row.
// Power-of-two BUCKETS: the row is read as the item is accepted, then compared and written back,
// with the result registered; other counts add a residue fold and a reciprocal reduction of the
// key (S_FOLD, S_QUOT, S_REM, S_FIX) before the row read in S_READ.
// Items are processed one at a time; a result not yet taken stalls the next write-back.
// Reset: synchronous; a clearing pass writes every row invalid before the first item
// is accepted.
module hashed_key_value_store_core
  import hkvs_pkg::*;
#(
  parameter int unsigned BUCKETS = 256,
  parameter int unsigned WAYS    = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int unsigned BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W   = WAYS * $bits(way_t);
  localparam bit          IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  // weights of the 16-bit key chunks modulo the bucket count, and the scaled reciprocal
  localparam longint unsigned FOLD_C1 = 64'd65536 % BUCKETS;
  localparam longint unsigned FOLD_C2 = (FOLD_C1 << 16) % BUCKETS;
  localparam longint unsigned FOLD_C3 = (FOLD_C2 << 16) % BUCKETS;
  localparam logic [32:0]     RECIP   = 33'((64'd1 << 34) / BUCKETS);

  typedef way_t [WAYS-1:0] row_t;

  state_t          state_r, state_nxt;
  in_item_t        req_r, req_nxt;
  logic [BW-1:0]   bucket_r, bucket_nxt;
  logic [33:0]     fold_r, fold_nxt;
  logic [32:0]     quot_r, quot_nxt;
  logic [BW:0]     rem_r, rem_nxt;
  logic [BW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic            ram_we, ram_re;
  logic [BW-1:0]   ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  row_t            row, new_row;
  logic            hit_any, free_any, exec_go, in_fire;
  logic [WW-1:0]   hit_idx, free_idx;
  logic [BW-1:0]   bucket_in, rem_fix;
  logic [33:0]     fold_sum, back_prod, rem_diff;
  logic [66:0]     quot_prod;
  logic            row_we;
  out_item_t       result;

  assign row = row_t'(ram_rdata);

  hkvs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshake
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // bucket of an incoming key for a power-of-two bucket count
  assign bucket_in = (BUCKETS == 1) ? '0 : in_item.key[BW-1:0];

  // key modulo the bucket count: chunk fold, reciprocal quotient, back-multiply, one fix-up
  always_comb begin
    fold_sum  = 34'(req_r.key[15:0])
              + 34'(req_r.key[31:16]) * 34'(FOLD_C1)
              + 34'(req_r.key[47:32]) * 34'(FOLD_C2)
              + 34'(req_r.key[62:48]) * 34'(FOLD_C3);
    quot_prod = 67'(fold_r) * 67'(RECIP);
    back_prod = 34'(quot_r) * 34'(BUCKETS);
    rem_diff  = fold_r - back_prod;
    rem_fix   = (rem_r >= (BW+1)'(BUCKETS)) ? BW'(rem_r - (BW+1)'(BUCKETS)) : rem_r[BW-1:0];
  end

  // lowest matching way and lowest free way
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row[w].valid && (row[w].key == req_r.key)) begin
        hit_any = 1'b1;
        hit_idx = WW'(w);
      end
      if (!row[w].valid) begin
        free_any = 1'b1;
        free_idx = WW'(w);
      end
    end
  end

  // operation on the bucket row
  always_comb begin
    new_row           = row;
    row_we            = 1'b0;
    result.status     = STAT_NOT_FOUND;
    result.read_value = '0;
    unique case (req_r.func)
      FUNC_INSERT: begin
        if (hit_any) begin
          new_row[hit_idx].value = req_r.value;
          row_we                 = 1'b1;
          result.status          = STAT_UPDATED;
        end else if (free_any) begin
          new_row[free_idx].valid = 1'b1;
          new_row[free_idx].key   = req_r.key;
          new_row[free_idx].value = req_r.value;
          row_we                  = 1'b1;
          result.status           = STAT_INSERTED;
        end else begin
          result.status = STAT_FULL;
        end
      end
      FUNC_DELETE: begin
        if (hit_any) begin
          new_row[hit_idx].valid = 1'b0;
          row_we                 = 1'b1;
          result.status          = STAT_DELETED;
        end
      end
      FUNC_SEARCH: begin
        if (hit_any) begin
          result.status     = STAT_FOUND;
          result.read_value = row[hit_idx].value;
        end else begin
          result.read_value = '1;
        end
      end
      default: begin
        result.status = STAT_NOT_FOUND;
      end
    endcase
  end

  // memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bucket_r;
    ram_wdata = new_row;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (exec_go) begin
      ram_we = row_we;
    end
    ram_re    = (in_fire && IS_POW2) || (state_r == S_READ);
    ram_raddr = (state_r == S_READ) ? bucket_r : bucket_in;
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    bucket_nxt    = bucket_r;
    fold_nxt      = fold_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == BW'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          req_nxt = in_item;
          if (IS_POW2) begin
            bucket_nxt = bucket_in;
            state_nxt  = S_EXEC;
          end else begin
            state_nxt  = S_FOLD;
          end
        end
      end
      S_FOLD: begin
        fold_nxt  = fold_sum;
        state_nxt = S_QUOT;
      end
      S_QUOT: begin
        quot_nxt  = quot_prod[66:34];
        state_nxt = S_REM;
      end
      S_REM: begin
        rem_nxt   = rem_diff[BW:0];
        state_nxt = S_FIX;
      end
      S_FIX: begin
        bucket_nxt = rem_fix;
        state_nxt  = S_READ;
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = result;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    bucket_r   <= bucket_nxt;
    fold_r     <= fold_nxt;
    quot_r     <= quot_nxt;
    rem_r      <= rem_nxt;
    out_item_r <= out_item_nxt;
  end

  // the row memory never sees a write and a read in one cycle
  assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
    else $error("row memory read and write in the same cycle");

  // no item is taken while the clearing pass runs
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_CLEAR) |-> !in_ready)
    else $error("item accepted during clearing pass");

  // a finished operation leaves a result and returns to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("operation completed without a result");

  // a result is only replaced after it was taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_item_r)))
    else $error("pending result overwritten");

endmodule
